@@ src/emec_pkg.sv @@
// Shared types and constants for the edge multiset equality checker.
`timescale 1ns / 1ps

package emec_pkg;

   // Fixed field widths of the channels
   localparam int EDGE_COUNT_W = 11;
   localparam int NODE_W       = 16;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_EDGES = 1024;
   localparam int DEF_NODE_BITS = 16;

   // Equality bits folded per register of the reduction stage
   localparam int GROUP_SIZE = 32;

   // List selector
   localparam logic LIST_ONE = 1'b0;
   localparam logic LIST_TWO = 1'b1;

   // Control broadcast to every cell
   typedef struct packed {
      logic ins;    // insert the key this cycle
      logic phase;  // list being filled
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_GROUP,
      ST_RESULT
   } state_type;

endpackage

@@ src/edge_multiset_equality_check_top.sv @@
// Top level of the edge multiset equality checker: control, cell chain, result register.
`timescale 1ns / 1ps

// Usage
//   req_*  : one undirected edge per transfer, two node numbers. The first
//            edge_count edges form list one, the next edge_count list two.
//   rsp_*  : one transfer per pair of lists, bit 0 set when both lists hold
//            the same multiset of edges.
//   csr_*  : edge_count write (0 reads as 1, values above MAX_EDGES saturate);
//            a write restarts the current pair and goes first: req_tready is
//            low while csr_valid is high.
// Each edge is inserted into a sorted chain of MAX_EDGES cells at once, so
// edges are taken at one per cycle while req_tready is high. After the last
// edge of list two the chain compares all cells in parallel and folds the
// result through one registered group stage into the response register;
// req_tready stays low from that transfer until the response is loaded.
// A pending response does not stop the next pair from filling; only the
// completion of a further pair waits for rsp_tready.
// Reset clears the counters, sets edge_count to 1 and drops rsp_tvalid; the
// cell contents need no clearing since only written entries are compared.
module edge_multiset_equality_check_top #(
   parameter int MAX_EDGES = emec_pkg::DEF_MAX_EDGES,
   parameter int NODE_BITS = emec_pkg::DEF_NODE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // edge: end_first [15:0], end_second [31:16]
   input  logic [2*emec_pkg::NODE_W-1:0]      req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // result: same [0], zero padding [7:1]
   output logic [7:0]                         rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [emec_pkg::EDGE_COUNT_W-1:0]  csr_data,
   input  logic                               csr_valid,
   output logic                               csr_ready
);
   import emec_pkg::*;

   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int KEY_W = 2 * NODE_BITS;
   localparam int VB    = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             phase_ff, phase_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_same_ff, rsp_same_in;

   logic                 req_xfer;
   logic                 csr_xfer;
   logic                 last_of_list;
   logic [NODE_BITS-1:0] node_a, node_b, node_lo, node_hi;
   logic [KEY_W-1:0]     key;
   cell_ctrl_type        ctrl;
   logic                 all_same;

   logic [KEY_W-1:0]     sel_val [MAX_EDGES];
   logic [MAX_EDGES-1:0] gt;
   logic [MAX_EDGES-1:0] eq;

   // a pending length write holds off edges
   assign req_tready = (state_ff == ST_FILL) && !csr_valid;
   assign csr_ready  = (state_ff == ST_FILL);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;

   // endpoints masked to the node width, smaller one first
   assign node_a  = NODE_BITS'(req_tdata[VB-1:0]);
   assign node_b  = NODE_BITS'(req_tdata[NODE_W +: VB]);
   assign node_lo = (node_a < node_b) ? node_a : node_b;
   assign node_hi = (node_a < node_b) ? node_b : node_a;
   assign key     = {node_lo, node_hi};

   assign ctrl.ins   = req_xfer;
   assign ctrl.phase = phase_ff;

   // sorted insertion chain
   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      if (i == 0) begin : g_head
         emec_cell #(.IDX(i), .CNT_W(CNT_W), .KEY_W(KEY_W)) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .fill     (fill_ff),
            .count    (n_ff),
            .key      (key),
            .prev_val (key),
            .prev_gt  (1'b0),
            .sel_val  (sel_val[i]),
            .gt       (gt[i]),
            .eq       (eq[i])
         );
      end else begin : g_body
         emec_cell #(.IDX(i), .CNT_W(CNT_W), .KEY_W(KEY_W)) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .fill     (fill_ff),
            .count    (n_ff),
            .key      (key),
            .prev_val (sel_val[i-1]),
            .prev_gt  (gt[i-1]),
            .sel_val  (sel_val[i]),
            .gt       (gt[i]),
            .eq       (eq[i])
         );
      end
   end

   emec_reduce #(.N_IN(MAX_EDGES), .GRP(GROUP_SIZE)) u_reduce (
      .clock    (clock),
      .en       (state_ff == ST_GROUP),
      .eq       (eq),
      .all_same (all_same)
   );

   assign last_of_list = (fill_ff == n_ff - CNT_W'(1));

   // state register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         n_ff         <= CNT_W'(1);
         fill_ff      <= '0;
         phase_ff     <= LIST_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_same_ff <= rsp_same_in;
   end

   // next state, counters and result register
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_same_in  = rsp_same_ff;

      unique case (state_ff)
         ST_FILL: begin
            if (csr_xfer) begin
               if (csr_data == '0) begin
                  n_in = CNT_W'(1);
               end else if (32'(csr_data) > 32'(MAX_EDGES)) begin
                  n_in = CNT_W'(MAX_EDGES);
               end else begin
                  n_in = CNT_W'(csr_data);
               end
               fill_in  = '0;
               phase_in = LIST_ONE;
            end else if (req_xfer) begin
               if (last_of_list) begin
                  fill_in = '0;
                  if (phase_ff == LIST_TWO) begin
                     phase_in = LIST_ONE;
                     state_in = ST_GROUP;
                  end else begin
                     phase_in = LIST_TWO;
                  end
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
         ST_GROUP: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_same_in  = all_same;
               state_in     = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_same_ff};

   // fill index always inside the current list
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < n_ff)
      else $error("fill index beyond list length");

   // completing list two starts the compare
   a_pair_done: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && phase_ff == LIST_TWO && last_of_list) |=> (state_ff == ST_GROUP))
      else $error("compare not started after list two");

   // result stage loads the response register when it is free
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && (!rsp_valid_ff || rsp_tready)) |=>
      (rsp_valid_ff && state_ff == ST_FILL))
      else $error("response not loaded");

   // a length write restarts the pair
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> (fill_ff == '0 && phase_ff == LIST_ONE && n_ff != '0))
      else $error("length write did not restart the pair");

endmodule

@@ src/emec_cell.sv @@
// One insertion cell: holds entry IDX of both sorted edge lists.
`timescale 1ns / 1ps

module emec_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 11,
   parameter int KEY_W = 32
) (
   input  logic                   clock,
   input  emec_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]       fill,
   input  logic [CNT_W-1:0]       count,
   input  logic [KEY_W-1:0]       key,
   input  logic [KEY_W-1:0]       prev_val,
   input  logic                   prev_gt,
   output logic [KEY_W-1:0]       sel_val,
   output logic                   gt,
   output logic                   eq
);
   import emec_pkg::*;

   logic [KEY_W-1:0] one_ff;
   logic [KEY_W-1:0] two_ff;
   logic [KEY_W-1:0] val_in;
   logic             take;

   // entry of the list being filled
   assign sel_val = (ctrl.phase == LIST_TWO) ? two_ff : one_ff;

   // occupied entry larger than the key moves one place right
   assign gt   = (CNT_W'(IDX) < fill) && (sel_val > key);
   assign take = gt || (CNT_W'(IDX) == fill);

   // left neighbour shifts in, or the key lands here
   assign val_in = prev_gt ? prev_val : key;

   // entries beyond the list length take no part in the compare
   assign eq = (CNT_W'(IDX) >= count) || (one_ff == two_ff);

   always_ff @(posedge clock) begin
      if (ctrl.ins && take) begin
         if (ctrl.phase == LIST_TWO) begin
            two_ff <= val_in;
         end else begin
            one_ff <= val_in;
         end
      end
   end

endmodule

@@ src/emec_reduce.sv @@
// Registered AND reduction of the per-cell equality bits.
`timescale 1ns / 1ps

module emec_reduce #(
   parameter int N_IN = 1024,
   parameter int GRP  = 32
) (
   input  logic            clock,
   input  logic            en,
   input  logic [N_IN-1:0] eq,
   output logic            all_same
);
   localparam int NGRP  = (N_IN + GRP - 1) / GRP;
   localparam int PAD_W = NGRP * GRP;

   logic [PAD_W-1:0] pad;
   logic [NGRP-1:0]  grp_ff;
   logic [NGRP-1:0]  grp_in;

   // unused tail reads as equal
   if (PAD_W > N_IN) begin : g_pad
      assign pad = {{(PAD_W - N_IN){1'b1}}, eq};
   end else begin : g_nopad
      assign pad = eq;
   end

   // one AND per group
   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      assign grp_in[g] = &pad[g*GRP +: GRP];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         grp_ff <= grp_in;
      end
   end

   assign all_same = &grp_ff;

endmodule

@@ verif/edge_multiset_equality_check_top_tb.sv @@
// Self-checking testbench for the edge multiset equality checker top level.
`timescale 1ns / 1ps

module edge_multiset_equality_check_top_tb;

   import emec_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 7;
   localparam int MAX_EDGES      = DEF_MAX_EDGES;
   localparam int SETTLE_CYCLES  = 6;      // padding after each drain for the block to settle
   localparam int WATCHDOG_LIMIT = 5000;   // cycles with no transfer at all
   localparam int RANDOM_EDGES   = 980;

   // One edge as it travels on req_tdata: end_first [15:0], end_second [31:16]
   typedef struct packed {
      logic [NODE_W-1:0] end_second;
      logic [NODE_W-1:0] end_first;
   } node_pair_type;

   typedef logic [2*NODE_W-1:0] edge_key_queue_type[$];

   typedef enum int {PAIR_EQUAL, PAIR_ALTERED, PAIR_NOISE} pair_kind_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic [2*NODE_W-1:0]      req_tdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [EDGE_COUNT_W-1:0]  csr_data   = '0;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;

   // Stimulus and scoreboard state
   node_pair_type            pending_edges[$];
   logic                     expected_same[$];
   logic                     req_taken = 1'b0;
   int                       edges_queued   = 0;
   int                       edges_accepted = 0;
   int                       errors         = 0;
   int                       pairs_equal    = 0;
   int                       pairs_differ   = 0;
   int                       csr_writes     = 0;

   // Predictor state: register copy and the two sorted edge lists
   logic [EDGE_COUNT_W-1:0]  edge_count_reg = 1;
   int                       edges_taken    = 0;
   edge_key_queue_type       list_one;
   edge_key_queue_type       list_two;

   // Sender pacing
   int                       burst_left = 0;
   int                       gap_left   = 0;

   // Receiver pacing
   ready_mode_type           ready_mode  = READY_ALWAYS;
   int                       mode_left   = 0;
   int                       stall_phase = 0;

   int                       idle_cycles = 0;

   edge_multiset_equality_check_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Edges per list, after zero and oversize counts are folded
   function automatic int active_count();
      int n;
      n = int'(edge_count_reg);
      if (n == 0) n = 1;
      if (n > MAX_EDGES) n = MAX_EDGES;
      return n;
   endfunction

   // Insertion keeps each list ordered by low endpoint, then high endpoint
   function automatic edge_key_queue_type with_key(edge_key_queue_type q,
                                                   logic [2*NODE_W-1:0] key);
      int pos;
      pos = q.size();
      while (pos > 0 && q[pos-1] > key) pos--;
      q.insert(pos, key);
      return q;
   endfunction

   // Predict the verdict stream from each accepted edge
   task automatic sort_in_edge(node_pair_type e);
      logic [NODE_W-1:0]   lo;
      logic [NODE_W-1:0]   hi;
      logic [2*NODE_W-1:0] key;
      int                  n;
      logic                equal;
      n = active_count();
      if (edges_taken >= 2 * n) edges_taken = 0;
      if (edges_taken == 0) begin
         list_one.delete();
         list_two.delete();
      end
      lo  = (e.end_first < e.end_second) ? e.end_first : e.end_second;
      hi  = (e.end_first < e.end_second) ? e.end_second : e.end_first;
      key = {lo, hi};
      if (edges_taken < n) list_one = with_key(list_one, key);
      else list_two = with_key(list_two, key);
      edges_taken++;
      if (edges_taken == 2 * n) begin
         equal = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (list_one[i] != list_two[i]) equal = 1'b0;
         end
         expected_same.push_back(equal);
         if (equal) pairs_equal++;
         else pairs_differ++;
         edges_taken = 0;
      end
   endtask

   // Node numbers: clustered small values for repeats, plus full range and extremes
   function automatic logic [NODE_W-1:0] random_node();
      case ($urandom_range(0, 7))
         0, 1:    return NODE_W'($urandom);
         2:       return $urandom_range(0, 1) ? '1 : '0;
         3:       return NODE_W'($urandom_range(65528, 65535));
         default: return NODE_W'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic node_pair_type random_pair();
      node_pair_type p;
      p.end_first  = random_node();
      p.end_second = random_node();
      return p;
   endfunction

   task automatic queue_edge(node_pair_type p);
      pending_edges.push_back(p);
      edges_queued++;
   endtask

   task automatic queue_nodes(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      node_pair_type p;
      p.end_first  = a;
      p.end_second = b;
      queue_edge(p);
   endtask

   // Two lists of n edges: list two is a shuffle of list one, altered or unrelated
   task automatic queue_list_pair(int n, pair_kind_type kind);
      node_pair_type first[$];
      node_pair_type second[$];
      node_pair_type tmp;
      int            j;
      int            k;
      for (int i = 0; i < n; i++) first.push_back(random_pair());
      if (kind == PAIR_NOISE) begin
         for (int i = 0; i < n; i++) second.push_back(random_pair());
      end else begin
         second = first;
         for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = second[i];
            second[i] = second[j];
            second[j] = tmp;
         end
         // undirected: endpoint order must not matter
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) begin
               tmp = second[i];
               second[i].end_first  = tmp.end_second;
               second[i].end_second = tmp.end_first;
            end
         end
         if (kind == PAIR_ALTERED) begin
            k = $urandom_range(0, n - 1);
            if (n > 1 && $urandom_range(0, 1)) second[k] = second[(k + 1) % n];
            else second[k].end_first ^= NODE_W'(1) << $urandom_range(0, NODE_W - 1);
         end
      end
      foreach (first[i]) queue_edge(first[i]);
      foreach (second[i]) queue_edge(second[i]);
   endtask

   // Wait until every edge is taken, every verdict has come and the block settles
   task automatic wait_for_drain();
      do @(negedge clock);
      while (edges_accepted != edges_queued || expected_same.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_edge_count(int value);
      @(negedge clock);
      csr_data  <= EDGE_COUNT_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      edge_count_reg = EDGE_COUNT_W'(value);
      edges_taken    = 0;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Edge sender: bursts of random length separated by random gaps
   always @(negedge clock) begin : drive_edges
      logic                next_valid;
      logic [2*NODE_W-1:0] next_data;
      node_pair_type       item;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_edges.size() > 0) begin
            item       = pending_edges.pop_front();
            next_valid = 1'b1;
            next_data  = item;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // Result receiver: switches between always ready, coin toss and sparse ready
   always @(negedge clock) begin : drive_ready
      logic ready_next;
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         mode_left  = $urandom_range(20, 300);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS: ready_next = 1'b1;
         READY_COIN:   ready_next = $urandom_range(0, 1);
         default:      ready_next = (stall_phase == 0);
      endcase
      stall_phase = (stall_phase + 1) % 8;
      rsp_tready <= ready_next;
   end

   // Transfer monitor and verdict check
   always @(posedge clock) begin : watch_transfers
      logic want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_same.size() == 0) begin
               $display("%0t ns: verdict with none pending, expected none, actual same=%0b",
                        $time, rsp_tdata[0]);
               errors++;
            end else begin
               want = expected_same.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $display("%0t ns: same mismatch, expected %0b, actual %0b",
                           $time, want, rsp_tdata[0]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            sort_in_edge(node_pair_type'(req_tdata));
            edges_accepted++;
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles, %0d verdicts outstanding",
                  $time, WATCHDOG_LIMIT, expected_same.size());
         $display("[edge_multiset_equality_check_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int            n;
      int            pairs;
      int            random_start;
      pair_kind_type kind;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset count of one: equal, swapped endpoints, extremes
      queue_nodes(16'h0000, 16'h0000);  queue_nodes(16'h0000, 16'h0000);
      queue_nodes(16'hFFFF, 16'h0000);  queue_nodes(16'h0000, 16'hFFFF);
      queue_nodes(16'hFFFF, 16'hFFFF);  queue_nodes(16'hFFFF, 16'hFFFE);
      queue_nodes(16'h5555, 16'hAAAA);  queue_nodes(16'hAAAA, 16'h5555);
      wait_for_drain();

      // Zero count behaves as one
      write_edge_count(0);
      queue_nodes(16'd1, 16'd2);  queue_nodes(16'd2, 16'd1);
      wait_for_drain();

      // Repeated edges: equal multisets, then same sets with different multiplicity
      write_edge_count(3);
      queue_nodes(16'd5, 16'd5);  queue_nodes(16'd3, 16'd9);  queue_nodes(16'd5, 16'd5);
      queue_nodes(16'd5, 16'd5);  queue_nodes(16'd9, 16'd3);  queue_nodes(16'd5, 16'd5);
      queue_nodes(16'd1, 16'd2);  queue_nodes(16'd1, 16'd2);  queue_nodes(16'd3, 16'd4);
      queue_nodes(16'd2, 16'd1);  queue_nodes(16'd4, 16'd3);  queue_nodes(16'd3, 16'd4);
      wait_for_drain();

      // A count write part way through a pair restarts it
      write_edge_count(MAX_EDGES);
      for (int i = 0; i < 5; i++) queue_edge(random_pair());
      wait_for_drain();
      write_edge_count(2);
      queue_list_pair(2, PAIR_EQUAL);
      wait_for_drain();

      // Oversize count: a short run gives no verdict, then a write discards it
      write_edge_count(2047);
      for (int i = 0; i < 20; i++) queue_edge(random_pair());
      wait_for_drain();

      // Random phases, mostly small counts
      random_start = edges_queued;
      while (edges_queued - random_start < RANDOM_EDGES) begin
         case ($urandom_range(0, 19))
            0:                   n = $urandom_range(33, 100);
            1, 2, 3, 4, 5:       n = $urandom_range(7, 32);
            default:             n = $urandom_range(1, 6);
         endcase
         write_edge_count((n == 1 && $urandom_range(0, 1)) ? 0 : n);
         pairs = $urandom_range(1, 1 + 60 / (2 * n));
         for (int p = 0; p < pairs; p++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3:                    kind = PAIR_NOISE;
               4, 5, 6, 7, 8, 9, 10:          kind = PAIR_ALTERED;
               default:                       kind = PAIR_EQUAL;
            endcase
            queue_list_pair(n, kind);
         end
         // occasionally leave a pair unfinished for the next write to discard
         if ($urandom_range(0, 7) == 0) begin
            for (int i = $urandom_range(1, 2 * n - 1); i > 0; i--) queue_edge(random_pair());
         end
         wait_for_drain();
      end

      wait_for_drain();
      $display("Edges sent: %0d over %0d edge_count writes, counts from zero to oversize.",
               edges_accepted, csr_writes);
      $display("List pairs judged: %0d equal, %0d different.", pairs_equal, pairs_differ);
      if (errors == 0 && expected_same.size() == 0) begin
         $display("[edge_multiset_equality_check_top] OK");
      end else begin
         $display("[edge_multiset_equality_check_top] ERROR");
      end
      $finish;
   end

endmodule
